@@ rtl/pfam_pkg.sv @@
package pfam_pkg;

	localparam int OPERAND_BITS = 256;
	localparam int WORD_BITS = 64;
	localparam int CFG_IDX_W = 2;
	localparam int CNT_W = $clog2(OPERAND_BITS);

	typedef logic [OPERAND_BITS-1:0] operand_t;
	typedef logic [WORD_BITS-1:0] word_t;

	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_MUL = 2'd1;
	localparam logic [1:0] ACT_INV = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	localparam logic [1:0] SEL_ONE = 2'd0;
	localparam logic [1:0] SEL_A = 2'd1;
	localparam logic [1:0] SEL_B = 2'd2;
	localparam logic [1:0] SEL_RES = 2'd3;

	typedef struct packed {
		logic load;
		logic init;
		logic [1:0] xsel;
		logic [1:0] ysel;
		logic dbl;
		logic addx;
		logic store;
		logic [1:0] dst;
		logic sum;
		logic clr;
		logic eshift;
	} pfam_cmd_t;

	typedef struct packed {
		logic p_zero;
		logic e_msb;
		logic [1:0] action;
	} pfam_status_t;

	// Returns (u + v) mod p for u, v below p, from the full carry-extended sum.
	function automatic operand_t add_mod(operand_t u, operand_t v, operand_t p);
		logic [OPERAND_BITS:0] s;
		s = {1'b0, u} + {1'b0, v};
		if (s >= {1'b0, p}) begin
			s = s - {1'b0, p};
		end
		return s[OPERAND_BITS-1:0];
	endfunction

endpackage

@@ rtl/pfam_in_if.sv @@
interface pfam_in_if import pfam_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] action;
	word_t a_word0;
	word_t a_word1;
	word_t a_word2;
	word_t a_word3;
	word_t b_word0;
	word_t b_word1;
	word_t b_word2;
	word_t b_word3;

	modport source (output valid, action, a_word0, a_word1, a_word2, a_word3,
		b_word0, b_word1, b_word2, b_word3, input ready);
	modport sink (input valid, action, a_word0, a_word1, a_word2, a_word3,
		b_word0, b_word1, b_word2, b_word3, output ready);
endinterface

@@ rtl/pfam_out_if.sv @@
interface pfam_out_if import pfam_pkg::*; ();
	logic valid;
	logic ready;
	word_t result_word0;
	word_t result_word1;
	word_t result_word2;
	word_t result_word3;

	modport source (output valid, result_word0, result_word1, result_word2,
		result_word3, input ready);
	modport sink (input valid, result_word0, result_word1, result_word2,
		result_word3, output ready);
endinterface

@@ rtl/prime_field_add_mul_inverse_top.sv @@
// Modular add, multiply and Fermat inverse over a 256-bit modulus written in four
// 64-bit configuration words. One transaction is handled at a time. Every modular
// multiplication, including the reduction of each operand on entry, runs on one
// shared shift-and-add unit that takes each operand bit through a double state and
// then an add state. An add sums the two reduced operands; an inverse squares for
// each bit of p-2 and multiplies by the operand for each one bit. A zero modulus or
// the ACT_NONE action gives a zero result.
module prime_field_add_mul_inverse_top import pfam_pkg::*; (
	input logic clk,
	input logic arst_n,
	pfam_in_if.sink in_ch,
	pfam_out_if.source out_ch,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input word_t cfg_data
);

	pfam_cmd_t cmd;
	pfam_status_t status;
	operand_t result;

	pfam_controller u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.status(status),
		.cmd(cmd)
	);

	pfam_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_action(in_ch.action),
		.in_a({in_ch.a_word3, in_ch.a_word2, in_ch.a_word1, in_ch.a_word0}),
		.in_b({in_ch.b_word3, in_ch.b_word2, in_ch.b_word1, in_ch.b_word0}),
		.cmd(cmd),
		.status(status),
		.result(result)
	);

	assign out_ch.result_word0 = result[WORD_BITS-1:0];
	assign out_ch.result_word1 = result[2*WORD_BITS-1:WORD_BITS];
	assign out_ch.result_word2 = result[3*WORD_BITS-1:2*WORD_BITS];
	assign out_ch.result_word3 = result[4*WORD_BITS-1:3*WORD_BITS];

endmodule

@@ rtl/pfam_datapath.sv @@
module pfam_datapath import pfam_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input word_t cfg_data,
	input logic [1:0] in_action,
	input operand_t in_a,
	input operand_t in_b,
	input pfam_cmd_t cmd,
	output pfam_status_t status,
	output operand_t result
);

	operand_t p_q;
	operand_t a_q;
	operand_t b_q;
	operand_t r_q;
	operand_t x_q;
	operand_t y_q;
	operand_t e_q;
	operand_t res_q;
	logic [1:0] action_q;
	operand_t add_u;
	operand_t add_v;
	operand_t sum_w;
	operand_t one_w;

	assign one_w = operand_t'(1);

	function automatic operand_t pick(logic [1:0] sel, operand_t one, operand_t a,
		operand_t b, operand_t res);
		operand_t v;
		unique case (sel)
			SEL_ONE: v = one;
			SEL_A: v = a;
			SEL_B: v = b;
			default: v = res;
		endcase
		return v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
		end else if (cfg_we) begin
			p_q[cfg_index*WORD_BITS +: WORD_BITS] <= cfg_data;
		end
	end

	always_comb begin
		priority if (cmd.sum) begin
			add_u = a_q;
			add_v = b_q;
		end else if (cmd.dbl) begin
			add_u = r_q;
			add_v = r_q;
		end else begin
			add_u = r_q;
			add_v = x_q;
		end
	end

	assign sum_w = add_mod(add_u, add_v, p_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= in_a;
			b_q <= in_b;
			action_q <= in_action;
			e_q <= p_q - operand_t'(2);
		end
		if (cmd.init) begin
			r_q <= '0;
			x_q <= pick(cmd.xsel, one_w, a_q, b_q, res_q);
			y_q <= pick(cmd.ysel, one_w, a_q, b_q, res_q);
		end
		if (cmd.dbl) begin
			r_q <= sum_w;
		end
		if (cmd.addx) begin
			if (y_q[OPERAND_BITS-1]) begin
				r_q <= sum_w;
			end
			y_q <= {y_q[OPERAND_BITS-2:0], 1'b0};
		end
		if (cmd.store) begin
			unique case (cmd.dst)
				SEL_A: a_q <= r_q;
				SEL_B: b_q <= r_q;
				default: res_q <= r_q;
			endcase
		end
		if (cmd.sum) begin
			res_q <= sum_w;
		end
		if (cmd.clr) begin
			res_q <= '0;
		end
		if (cmd.eshift) begin
			e_q <= {e_q[OPERAND_BITS-2:0], 1'b0};
		end
	end

	assign status.p_zero = (p_q == '0);
	assign status.e_msb = e_q[OPERAND_BITS-1];
	assign status.action = action_q;
	assign result = res_q;

endmodule

@@ rtl/pfam_controller.sv @@
module pfam_controller import pfam_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input pfam_status_t status,
	output pfam_cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INIT = 4'd1;
	localparam logic [3:0] S_DBL = 4'd2;
	localparam logic [3:0] S_ADD = 4'd3;
	localparam logic [3:0] S_STORE = 4'd4;
	localparam logic [3:0] S_NEXT = 4'd5;
	localparam logic [3:0] S_SUM = 4'd6;
	localparam logic [3:0] S_CLR = 4'd7;
	localparam logic [3:0] S_EDEC = 4'd8;
	localparam logic [3:0] S_OUT = 4'd9;

	localparam logic [2:0] PH_RA = 3'd0;
	localparam logic [2:0] PH_RB = 3'd1;
	localparam logic [2:0] PH_OP = 3'd2;
	localparam logic [2:0] PH_ONE = 3'd3;
	localparam logic [2:0] PH_SQ = 3'd4;
	localparam logic [2:0] PH_MA = 3'd5;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(OPERAND_BITS - 1);

	logic [3:0] state_q, state_d;
	logic [2:0] phase_q, phase_d;
	logic [CNT_W-1:0] bit_q, bit_d;
	logic [CNT_W-1:0] exp_q, exp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_RA;
			bit_q <= '0;
			exp_q <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			bit_q <= bit_d;
			exp_q <= exp_d;
		end
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		bit_d = bit_q;
		exp_d = exp_q;
		cmd = '0;
		in_ready = (state_q == S_IDLE);
		out_valid = (state_q == S_OUT);
		unique case (phase_q)
			PH_RA: begin
				cmd.xsel = SEL_ONE;
				cmd.ysel = SEL_A;
				cmd.dst = SEL_A;
			end
			PH_RB: begin
				cmd.xsel = SEL_ONE;
				cmd.ysel = SEL_B;
				cmd.dst = SEL_B;
			end
			PH_OP: begin
				cmd.xsel = SEL_A;
				cmd.ysel = SEL_B;
				cmd.dst = SEL_RES;
			end
			PH_ONE: begin
				cmd.xsel = SEL_ONE;
				cmd.ysel = SEL_ONE;
				cmd.dst = SEL_RES;
			end
			PH_SQ: begin
				cmd.xsel = SEL_RES;
				cmd.ysel = SEL_RES;
				cmd.dst = SEL_RES;
			end
			default: begin
				cmd.xsel = SEL_RES;
				cmd.ysel = SEL_A;
				cmd.dst = SEL_RES;
			end
		endcase
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					phase_d = PH_RA;
					state_d = status.p_zero ? S_CLR : S_INIT;
				end
			end
			S_INIT: begin
				cmd.init = 1'b1;
				bit_d = CNT_MAX;
				state_d = S_DBL;
			end
			S_DBL: begin
				cmd.dbl = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.addx = 1'b1;
				if (bit_q == '0) begin
					state_d = S_STORE;
				end else begin
					bit_d = bit_q - 1'b1;
					state_d = S_DBL;
				end
			end
			S_STORE: begin
				cmd.store = 1'b1;
				state_d = S_NEXT;
			end
			S_NEXT: begin
				unique case (phase_q)
					PH_RA: begin
						phase_d = PH_RB;
						state_d = S_INIT;
					end
					PH_RB: begin
						unique case (status.action)
							ACT_ADD: state_d = S_SUM;
							ACT_MUL: begin
								phase_d = PH_OP;
								state_d = S_INIT;
							end
							ACT_INV: begin
								phase_d = PH_ONE;
								state_d = S_INIT;
							end
							default: state_d = S_CLR;
						endcase
					end
					PH_ONE: begin
						exp_d = CNT_MAX;
						phase_d = PH_SQ;
						state_d = S_INIT;
					end
					PH_SQ: begin
						if (status.e_msb) begin
							phase_d = PH_MA;
							state_d = S_INIT;
						end else begin
							state_d = S_EDEC;
						end
					end
					PH_MA: state_d = S_EDEC;
					default: state_d = S_OUT;
				endcase
			end
			S_EDEC: begin
				cmd.eshift = 1'b1;
				if (exp_q == '0) begin
					state_d = S_OUT;
				end else begin
					exp_d = exp_q - 1'b1;
					phase_d = PH_SQ;
					state_d = S_INIT;
				end
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_OUT;
			end
			S_CLR: begin
				cmd.clr = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ rtl/pfam_checker.sv @@
module pfam_checker import pfam_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input operand_t result
);

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result))
		else $error("stalled result changed");

	// The block takes nothing while a result waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted while result pending");

	// After a transaction is accepted the block is busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !out_valid)
		else $error("no work after accept");

	// A delivered result frees the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready && !out_valid)
		else $error("not idle after delivery");

endmodule

bind prime_field_add_mul_inverse_top pfam_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.result({out_ch.result_word3, out_ch.result_word2, out_ch.result_word1,
		out_ch.result_word0})
);
